// ===== design/msp_pkg.sv =====
// Package for the multi-stack push block: sizing constants, status codes,
// the configuration struct and address helpers. No dependencies.
package msp_pkg;

    localparam int NUM_STACKS = 3;
    localparam int MAX_DEPTH  = 256;

    localparam int IDX_W  = $clog2(NUM_STACKS);
    localparam int FILL_W = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_STACKS * MAX_DEPTH);
    localparam int CAP_W  = 9;
    localparam int WORD_W = 32;
    localparam int PLACES = 3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BEYOND    = 2'd3;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic             clear;
        logic [CAP_W-1:0] capacity;
    } cfg_t;

    function automatic logic [ADDR_W-1:0] stack_base(input logic [IDX_W-1:0] idx);
        logic [ADDR_W+IDX_W-1:0] prod;
        prod = (ADDR_W + IDX_W)'(idx) * (ADDR_W + IDX_W)'(MAX_DEPTH);
        return prod[ADDR_W-1:0];
    endfunction

endpackage

// ===== design/multi_stack_push_with_fill_order.sv =====
// Top level of the multi-stack block: capacity register on the APB port,
// sequencer and word store. Depends on msp_pkg, msp_core and msp_ram.

// Holds NUM_STACKS stacks of signed 32-bit words in one single-port store of
// NUM_STACKS*MAX_DEPTH words, plus a fill counter per stack and a fill-order list.
// Items are handled one at a time and in_stall is high while one is in work.
// A push that is taken passes through the states EXEC, WALK and DONE; in WALK the
// fill-order list is walked one entry per cycle, for 1 to NUM_STACKS steps. A read
// of a stored word passes through EXEC, RDWAIT for the registered store read, and
// DONE, and a refused item goes from EXEC to DONE. A finished result waits in the
// output register while the next item is accepted. Writing the capacity register
// empties all stacks at once and leaves the fill order unchanged; it must only be
// written while the block is idle. No clearing pass is needed after reset.
module multi_stack_push_with_fill_order
    import msp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     mode,
    input  logic [1:0]               stack_index,
    input  logic signed [WORD_W-1:0] value,
    input  logic [7:0]               position,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [8:0]               fill,
    output logic signed [WORD_W-1:0] read_value,
    output logic [1:0]               order_first,
    output logic [1:0]               order_second,
    output logic [1:0]               order_third
);

    logic [CAP_W-1:0]  capacity_reg;
    logic              cap_write;
    cfg_t              cfg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    assign pready    = 1'b1;
    assign cap_write = psel && penable && pwrite && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : 32'(capacity_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else if (cap_write)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign cfg.clear    = cap_write;
    assign cfg.capacity = capacity_reg;

    msp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .stack_index  (stack_index),
        .value        (value),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .fill         (fill),
        .read_value   (read_value),
        .order_first  (order_first),
        .order_second (order_second),
        .order_third  (order_third),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata)
    );

    msp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_STACKS * MAX_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

// ===== design/msp_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/msp_core.sv =====
// Sequencer of the multi-stack block: fill counters, fill-order list, store
// access, and the result register. Depends on msp_pkg.
module msp_core
    import msp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     mode,
    input  logic [1:0]               stack_index,
    input  logic signed [WORD_W-1:0] value,
    input  logic [7:0]               position,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [8:0]               fill,
    output logic signed [WORD_W-1:0] read_value,
    output logic [1:0]               order_first,
    output logic [1:0]               order_second,
    output logic [1:0]               order_third,
    output logic                     ram_we,
    output logic [ADDR_W-1:0]        ram_addr,
    output logic [WORD_W-1:0]        ram_wdata,
    input  logic [WORD_W-1:0]        ram_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                mode_reg;
    logic                idx_ok_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [WORD_W-1:0]   value_reg;
    logic [7:0]          pos_reg;
    logic [FILL_W-1:0]   fill_reg [NUM_STACKS];
    logic [IDX_W-1:0]    order_reg [NUM_STACKS];
    logic [IDX_W-1:0]    ptr_reg;
    logic [FILL_W-1:0]   res_fill_reg;
    logic [1:0]          res_status_reg;
    logic [WORD_W-1:0]   res_rd_reg;

    logic                out_valid_reg;
    logic [1:0]          out_status_reg;
    logic [8:0]          out_fill_reg;
    logic [WORD_W-1:0]   out_rd_reg;
    logic [1:0]          out_order_reg [PLACES];

    logic [IDX_W+1:0]    idx_wide;
    logic [FILL_W-1:0]   fill_cur;
    logic [31:0]         cap_eff;
    logic                is_full;
    logic                is_beyond;
    logic [IDX_W-1:0]    found_pos;
    logic [IDX_W:0]      walk_next;
    logic [IDX_W-1:0]    walk_other;
    logic                walk_stop;
    logic                slot_free;
    logic [FILL_W+8:0]   fill_wide;
    logic [IDX_W+1:0]    order_wide [PLACES];

    assign idx_wide  = (IDX_W + 2)'(stack_index);
    assign fill_cur  = fill_reg[idx_reg];
    assign cap_eff   = (32'(cfg.capacity) > 32'(MAX_DEPTH)) ? 32'(MAX_DEPTH)
                                                            : 32'(cfg.capacity);
    assign is_full   = 32'(fill_cur) >= cap_eff;
    assign is_beyond = (32'(pos_reg) >= 32'(fill_cur)) || (32'(pos_reg) >= 32'(MAX_DEPTH));
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        found_pos = '0;
        for (int i = 0; i < NUM_STACKS; i++)
        begin
            if (order_reg[i] == idx_reg)
            begin
                found_pos = IDX_W'(i);
            end
        end
    end

    assign walk_next  = (IDX_W + 1)'(ptr_reg) + (IDX_W + 1)'(1);
    assign walk_other = order_reg[walk_next[IDX_W-1:0]];
    assign walk_stop  = (32'(walk_next) >= 32'(NUM_STACKS))
                        || (fill_reg[walk_other] >= res_fill_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = stack_base(idx_reg) + ADDR_W'(pos_reg);
        ram_wdata = value_reg;
        if (state_reg == S_EXEC && idx_ok_reg && mode_reg == MODE_PUSH && !is_full)
        begin
            ram_we   = 1'b1;
            ram_addr = stack_base(idx_reg) + ADDR_W'(fill_cur);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!idx_ok_reg)
                begin
                    state_next = S_DONE;
                end
                else if (mode_reg == MODE_PUSH)
                begin
                    state_next = is_full ? S_DONE : S_WALK;
                end
                else
                begin
                    state_next = is_beyond ? S_DONE : S_RDWAIT;
                end
            end
            S_RDWAIT:
            begin
                state_next = S_DONE;
            end
            S_WALK:
            begin
                if (walk_stop)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                fill_reg[i]  <= '0;
                order_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.clear)
            begin
                for (int i = 0; i < NUM_STACKS; i++)
                begin
                    fill_reg[i] <= '0;
                end
            end
            if (state_reg == S_EXEC && ram_we)
            begin
                fill_reg[idx_reg] <= fill_cur + FILL_W'(1);
                ptr_reg           <= found_pos;
            end
            if (state_reg == S_WALK && !walk_stop)
            begin
                order_reg[walk_next[IDX_W-1:0]] <= order_reg[ptr_reg];
                order_reg[ptr_reg]              <= walk_other;
                ptr_reg                         <= walk_next[IDX_W-1:0];
            end
            if (state_reg == S_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        fill_wide = (FILL_W + 9)'(res_fill_reg);
        for (int p = 0; p < PLACES; p++)
        begin
            order_wide[p] = (p < NUM_STACKS) ? (IDX_W + 2)'(order_reg[p % NUM_STACKS]) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            mode_reg   <= mode;
            idx_ok_reg <= 32'(stack_index) < 32'(NUM_STACKS);
            idx_reg    <= idx_wide[IDX_W-1:0];
            value_reg  <= value;
            pos_reg    <= position;
        end
        if (state_reg == S_EXEC)
        begin
            res_rd_reg <= '0;
            if (!idx_ok_reg)
            begin
                res_status_reg <= ST_BAD_INDEX;
                res_fill_reg   <= '0;
            end
            else if (mode_reg == MODE_PUSH)
            begin
                res_status_reg <= is_full ? ST_FULL : ST_OK;
                res_fill_reg   <= is_full ? fill_cur : fill_cur + FILL_W'(1);
            end
            else
            begin
                res_status_reg <= is_beyond ? ST_BEYOND : ST_OK;
                res_fill_reg   <= fill_cur;
            end
        end
        if (state_reg == S_RDWAIT)
        begin
            res_rd_reg <= ram_rdata;
        end
        if (state_reg == S_DONE && slot_free)
        begin
            out_status_reg <= res_status_reg;
            out_fill_reg   <= fill_wide[8:0];
            out_rd_reg     <= res_rd_reg;
            for (int p = 0; p < PLACES; p++)
            begin
                out_order_reg[p] <= order_wide[p][1:0];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign fill         = out_fill_reg;
    assign read_value   = out_rd_reg;
    assign order_first  = out_order_reg[0];
    assign order_second = out_order_reg[1];
    assign order_third  = out_order_reg[2];

    a_walk_tracks_pushed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> order_reg[ptr_reg] == idx_reg)
        else $error("Walk pointer lost the pushed stack.");

    a_walk_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> fill_reg[idx_reg] == res_fill_reg)
        else $error("Pushed stack fill differs from the reported fill.");

    a_write_only_push: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EXEC && mode_reg == MODE_PUSH && idx_ok_reg))
        else $error("Store written outside an accepted push.");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && slot_free) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("Finished item was not delivered.");

endmodule

// ===== test/tb.sv =====
// Testbench for multi_stack_push_with_fill_order: a directed table, then random
// phases at several capacities, checked against an in-bench stack predictor.
// Depends on msp_pkg and the block's RTL only.
module tb
    import msp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_CAPACITY = 3'd0;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [1:0]        st;
        logic [8:0]        depth;
        logic [WORD_W-1:0] word;
        logic [1:0]        first;
        logic [1:0]        second;
        logic [1:0]        third;
    } reply_t;

    typedef enum logic [1:0] {ROW_PUSH, ROW_READ, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [1:0]        idx;
        logic [WORD_W-1:0] val;
        logic [7:0]        pos;
        logic [CAP_W-1:0]  cap;
        bit                typed;
        reply_t            want;
    } row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [2:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     mode = MODE_PUSH;
    logic [1:0]               stack_index = '0;
    logic signed [WORD_W-1:0] value = '0;
    logic [7:0]               position = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic [8:0]               fill;
    logic signed [WORD_W-1:0] read_value;
    logic [1:0]               order_first;
    logic [1:0]               order_second;
    logic [1:0]               order_third;

    logic signed [WORD_W-1:0] stack_words [NUM_STACKS][MAX_DEPTH];
    logic [FILL_W-1:0]        stack_depth [NUM_STACKS];
    logic [1:0]               fill_rank [NUM_STACKS];
    logic [CAP_W-1:0]         cap_setting;

    reply_t pending_replies[$];
    row_t   drill[$];
    int     errors = 0;
    bit     calm = 1'b0;
    int     sink_hold = 0;

    multi_stack_push_with_fill_order dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .stack_index  (stack_index),
        .value        (value),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .fill         (fill),
        .read_value   (read_value),
        .order_first  (order_first),
        .order_second (order_second),
        .order_third  (order_third)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic reply_t apply_stack_op(input logic m, input logic [1:0] idx,
                                              input logic [WORD_W-1:0] val,
                                              input logic [7:0] pos);
        reply_t     r;
        int         limit;
        int         at;
        int         n;
        logic [1:0] t;
        r = '0;
        limit = (cap_setting > MAX_DEPTH) ? MAX_DEPTH : cap_setting;
        if (idx >= NUM_STACKS)
        begin
            r.st = ST_BAD_INDEX;
        end
        else if (m == MODE_PUSH)
        begin
            if (stack_depth[idx] >= limit)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                r.st = ST_OK;
                stack_words[idx][stack_depth[idx]] = val;
                stack_depth[idx] = stack_depth[idx] + 1'b1;
                at = 0;
                while (at < NUM_STACKS && fill_rank[at] != idx)
                    at++;
                for (n = at + 1; n < NUM_STACKS; n++)
                begin
                    if (stack_depth[fill_rank[n]] >= stack_depth[idx])
                        break;
                    t = fill_rank[n];
                    fill_rank[n] = fill_rank[n-1];
                    fill_rank[n-1] = t;
                end
            end
            r.depth = stack_depth[idx];
        end
        else
        begin
            r.depth = stack_depth[idx];
            if (pos >= stack_depth[idx])
                r.st = ST_BEYOND;
            else
                r.word = stack_words[idx][pos];
        end
        r.first  = fill_rank[0];
        r.second = fill_rank[1];
        r.third  = fill_rank[2];
        return r;
    endfunction

    task automatic offer_item(input logic m, input logic [1:0] idx,
                              input logic [WORD_W-1:0] val, input logic [7:0] pos,
                              input bit typed, input reply_t want);
        int     gap;
        reply_t predicted;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        stack_index <= idx;
        value       <= val;
        position    <= pos;
        do
            @(posedge clk);
        while (in_stall);
        predicted = apply_stack_op(m, idx, val, pos);
        pending_replies.push_back(typed ? want : predicted);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAPACITY;
        pwdata  <= {{(32 - CAP_W){1'b0}}, cap};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_setting = cap;
        for (int s = 0; s < NUM_STACKS; s++)
            stack_depth[s] = '0;
    endtask

    task automatic random_phase(input logic [CAP_W-1:0] cap, input int count,
                                input int focus_pct, input int push_pct);
        int                focus;
        logic              m;
        logic [1:0]        idx;
        logic [WORD_W-1:0] val;
        logic [7:0]        pos;
        write_capacity(cap);
        calm = ($urandom_range(0, 3) == 0);
        focus = $urandom_range(0, NUM_STACKS - 1);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 6)
                idx = 2'd3;
            else if ($urandom_range(0, 99) < focus_pct)
                idx = 2'(focus);
            else
                idx = 2'($urandom_range(0, NUM_STACKS - 1));
            m = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_READ;
            case ($urandom_range(0, 15))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'hFFFF_FFFF;
                3:       val = 32'h0000_0000;
                default: val = $urandom;
            endcase
            if (idx < NUM_STACKS && stack_depth[idx] != 0 && $urandom_range(0, 9) < 8)
                pos = 8'($urandom_range(0, stack_depth[idx] - 1));
            else
                pos = 8'($urandom_range(0, 255));
            offer_item(m, idx, val, pos, 1'b0, '0);
        end
    endtask

    function automatic row_t row(input row_kind_t kind, input logic [1:0] idx,
                                 input logic [WORD_W-1:0] val, input logic [7:0] pos,
                                 input logic [CAP_W-1:0] cap, input bit typed,
                                 input reply_t want);
        row_t r;
        r.kind  = kind;
        r.idx   = idx;
        r.val   = val;
        r.pos   = pos;
        r.cap   = cap;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (sink_hold == 0 && !calm && $urandom_range(0, 5) == 0)
            sink_hold = pick_gap();
        if (sink_hold > 0)
        begin
            out_stall <= 1'b1;
            sink_hold--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, fill, read_value, order_first, order_second, order_third};
            if (pending_replies.size() == 0)
            begin
                flag_mismatch("result arrived with none expected");
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.st !== want.st)
                    flag_mismatch($sformatf("status %0d, expected %0d", got.st, want.st));
                if (got.depth !== want.depth)
                    flag_mismatch($sformatf("fill %0d, expected %0d", got.depth, want.depth));
                if (got.word !== want.word)
                    flag_mismatch($sformatf("read_value %h, expected %h",
                                            got.word, want.word));
                if (got.first !== want.first)
                    flag_mismatch($sformatf("order_first %0d, expected %0d",
                                            got.first, want.first));
                if (got.second !== want.second)
                    flag_mismatch($sformatf("order_second %0d, expected %0d",
                                            got.second, want.second));
                if (got.third !== want.third)
                    flag_mismatch($sformatf("order_third %0d, expected %0d",
                                            got.third, want.third));
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        reply_t at_reset_full;
        reply_t at_reset_beyond;
        reply_t at_reset_bad;
        cap_setting = '0;
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            stack_depth[s] = '0;
            fill_rank[s] = 2'(s);
        end
        at_reset_full   = '{ST_FULL, 9'd0, 32'd0, 2'd0, 2'd1, 2'd2};
        at_reset_beyond = '{ST_BEYOND, 9'd0, 32'd0, 2'd0, 2'd1, 2'd2};
        at_reset_bad    = '{ST_BAD_INDEX, 9'd0, 32'd0, 2'd0, 2'd1, 2'd2};

        drill.push_back(row(ROW_PUSH, 2'd0, 32'd7, 8'd0, '0, 1'b1, at_reset_full));
        drill.push_back(row(ROW_READ, 2'd1, 32'd0, 8'd0, '0, 1'b1, at_reset_beyond));
        drill.push_back(row(ROW_PUSH, 2'd3, 32'hFFFF_FFFF, 8'd0, '0, 1'b1, at_reset_bad));
        drill.push_back(row(ROW_READ, 2'd3, 32'd0, 8'd255, '0, 1'b1, at_reset_bad));
        drill.push_back(row(ROW_CAP, 2'd0, 32'd0, 8'd0, 9'd2, 1'b0, '0));
        drill.push_back(row(ROW_PUSH, 2'd2, 32'h7FFF_FFFF, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_PUSH, 2'd0, 32'h8000_0000, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_PUSH, 2'd0, 32'hFFFF_FFFF, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_PUSH, 2'd0, 32'd0, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_READ, 2'd0, 32'd0, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_READ, 2'd0, 32'd0, 8'd1, '0, 1'b0, '0));
        drill.push_back(row(ROW_READ, 2'd0, 32'd0, 8'd2, '0, 1'b0, '0));
        drill.push_back(row(ROW_READ, 2'd2, 32'd0, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_PUSH, 2'd1, 32'h5555_5555, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_PUSH, 2'd1, 32'hAAAA_AAAA, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_READ, 2'd1, 32'd0, 8'd1, '0, 1'b0, '0));
        drill.push_back(row(ROW_CAP, 2'd0, 32'd0, 8'd0, 9'd511, 1'b0, '0));
        drill.push_back(row(ROW_PUSH, 2'd2, 32'd1, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_READ, 2'd2, 32'd0, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_READ, 2'd1, 32'd0, 8'd0, '0, 1'b0, '0));
        drill.push_back(row(ROW_READ, 2'd2, 32'd0, 8'd255, '0, 1'b0, '0));
        drill.push_back(row(ROW_PUSH, 2'd3, 32'd5, 8'd128, '0, 1'b0, '0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill[i])
        begin
            if (drill[i].kind == ROW_CAP)
                write_capacity(drill[i].cap);
            else
                offer_item(drill[i].kind == ROW_PUSH ? MODE_PUSH : MODE_READ, drill[i].idx,
                           drill[i].val, drill[i].pos, drill[i].typed, drill[i].want);
        end

        random_phase(9'd4, 60, 40, 60);
        random_phase(9'd511, 400, 90, 85);
        random_phase(9'd1, 50, 40, 60);
        random_phase(9'd0, 40, 40, 60);
        random_phase(9'd17, 60, 40, 65);
        random_phase(9'd256, 70, 60, 75);
        random_phase(9'($urandom_range(0, 511)), 60, 40, 60);
        random_phase(9'd2, 50, 40, 60);

        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
